>>> rtl/core/ctu_pkg.sv
package ctu_pkg;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_SET_MIN = 3'd1;
  localparam logic [2:0] MODE_SET_SEC = 3'd2;
  localparam logic [2:0] MODE_RUNNING = 3'd3;
  localparam logic [2:0] MODE_PAUSED  = 3'd4;
  localparam logic [2:0] MODE_ALARM   = 3'd5;

  localparam logic [1:0] BTN_RELEASED = 2'd0;
  localparam logic [1:0] BTN_LEFT     = 2'd1;
  localparam logic [1:0] BTN_MIDDLE   = 2'd2;
  localparam logic [1:0] BTN_RIGHT    = 2'd3;

  localparam logic [6:0] MINUTES_TOP = 7'd99;
  localparam logic [5:0] SECONDS_TOP = 6'd59;

  localparam logic [15:0] SECOND_PERIOD_RST = 16'd1000;
  localparam logic [15:0] BLINK_HALF_RST    = 16'd500;

  localparam logic CFG_SECOND_PERIOD = 1'b0;
  localparam logic CFG_BLINK_HALF    = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  preset_min;
    logic [5:0]  preset_sec;
    logic [6:0]  remain_min;
    logic [5:0]  remain_sec;
    logic [15:0] sec_cnt;
    logic [15:0] blink_cnt;
    logic        blink_phase;
  } ctu_state_t;

  typedef struct packed {
    logic [6:0] show_minutes;
    logic [5:0] show_seconds;
    logic       colon_lit;
    logic       blank_display;
    logic       alarm_start;
    logic       alarm_stop;
    logic [2:0] mode_now;
  } ctu_result_t;

  typedef struct packed {
    logic [15:0] second_period_ms;
    logic [15:0] blink_half_period_ms;
  } ctu_cfg_t;

endpackage

>>> rtl/core/ctu_if.sv
interface ctu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] button;
  logic       ms_tick;

  modport source (output valid, output button, output ms_tick, input ready);
  modport sink (input valid, input button, input ms_tick, output ready);
endinterface

interface ctu_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] show_minutes;
  logic [5:0] show_seconds;
  logic       colon_lit;
  logic       blank_display;
  logic       alarm_start;
  logic       alarm_stop;
  logic [2:0] mode_now;

  modport source (
    output valid, output show_minutes, output show_seconds, output colon_lit,
    output blank_display, output alarm_start, output alarm_stop, output mode_now,
    input ready
  );
  modport sink (
    input valid, input show_minutes, input show_seconds, input colon_lit,
    input blank_display, input alarm_start, input alarm_stop, input mode_now,
    output ready
  );
endinterface

>>> rtl/core/countdown_timer_controller_unit.sv
// Minute:second countdown controller driven by decoded button presses and a
// millisecond flag. Every accepted item updates the mode, preset, remaining
// time and blink state and yields exactly one result item, held in an
// output register; an item is taken every cycle the output register is
// empty or being drained, so the block sustains one item per clock while
// the output drains, and each result is registered in the cycle after accept.
// Registers 0 (second period) and 1 (blink half period) are written through
// the plain write port and reset to 1000 and 500 ms.
module countdown_timer_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  ctu_in_if.sink      in_i,
  ctu_out_if.source   out_o
);
  import ctu_pkg::*;

  ctu_cfg_t    cfg_q;
  ctu_state_t  st_q;
  ctu_state_t  st_d;
  ctu_result_t res_d;
  ctu_result_t res_q;
  logic        out_valid_q;
  logic        accept;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.second_period_ms     <= SECOND_PERIOD_RST;
      cfg_q.blink_half_period_ms <= BLINK_HALF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SECOND_PERIOD: cfg_q.second_period_ms     <= cfg_data_i;
        CFG_BLINK_HALF:    cfg_q.blink_half_period_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ctu_step u_step (
    .st_i      (st_q),
    .cfg_i     (cfg_q),
    .button_i  (in_i.button),
    .ms_tick_i (in_i.ms_tick),
    .st_o      (st_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode        <= MODE_IDLE;
      st_q.preset_min  <= 7'd0;
      st_q.preset_sec  <= 6'd0;
      st_q.remain_min  <= 7'd0;
      st_q.remain_sec  <= 6'd0;
      st_q.sec_cnt     <= 16'd0;
      st_q.blink_cnt   <= 16'd0;
      st_q.blink_phase <= 1'b1;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.show_minutes  = res_q.show_minutes;
  assign out_o.show_seconds  = res_q.show_seconds;
  assign out_o.colon_lit     = res_q.colon_lit;
  assign out_o.blank_display = res_q.blank_display;
  assign out_o.alarm_start   = res_q.alarm_start;
  assign out_o.alarm_stop    = res_q.alarm_stop;
  assign out_o.mode_now      = res_q.mode_now;

endmodule

>>> rtl/core/ctu_step.sv
module ctu_step (
  input  ctu_pkg::ctu_state_t  st_i,
  input  ctu_pkg::ctu_cfg_t    cfg_i,
  input  logic [1:0]           button_i,
  input  logic                 ms_tick_i,
  output ctu_pkg::ctu_state_t  st_o,
  output ctu_pkg::ctu_result_t res_o
);
  import ctu_pkg::*;

  logic [16:0] sec_sum;
  logic [16:0] sec_wrap;
  logic        sec_hit;
  logic [16:0] blink_sum;
  logic        blink_hit;
  logic        start_pulse;
  logic        stop_pulse;
  ctu_state_t  st;
  logic [6:0]  dmin;
  logic [5:0]  dsec;
  logic        colon;
  logic        blank;

  assign sec_sum   = {1'b0, st_i.sec_cnt} + {16'b0, ms_tick_i};
  assign sec_hit   = sec_sum >= {1'b0, cfg_i.second_period_ms};
  assign sec_wrap  = sec_sum - {1'b0, cfg_i.second_period_ms};
  assign blink_sum = {1'b0, st_i.blink_cnt} + {16'b0, ms_tick_i};
  assign blink_hit = blink_sum >= {1'b0, cfg_i.blink_half_period_ms};

  always_comb begin
    st          = st_i;
    start_pulse = 1'b0;
    stop_pulse  = 1'b0;
    case (st_i.mode)
      MODE_SET_MIN: begin
        if (button_i == BTN_LEFT) begin
          st.preset_min = (st_i.preset_min == 7'd0) ? MINUTES_TOP : st_i.preset_min - 7'd1;
        end else if (button_i == BTN_RIGHT) begin
          st.preset_min = (st_i.preset_min >= MINUTES_TOP) ? 7'd0 : st_i.preset_min + 7'd1;
        end else if (button_i == BTN_MIDDLE) begin
          st.mode = MODE_SET_SEC;
        end
      end
      MODE_SET_SEC: begin
        if (button_i == BTN_LEFT) begin
          st.preset_sec = (st_i.preset_sec == 6'd0) ? SECONDS_TOP : st_i.preset_sec - 6'd1;
        end else if (button_i == BTN_RIGHT) begin
          st.preset_sec = (st_i.preset_sec >= SECONDS_TOP) ? 6'd0 : st_i.preset_sec + 6'd1;
        end else if (button_i == BTN_MIDDLE) begin
          st.mode = MODE_IDLE;
        end
      end
      MODE_RUNNING: begin
        if (button_i == BTN_MIDDLE) begin
          st.mode = MODE_PAUSED;
        end
        if (sec_hit) begin
          st.sec_cnt = sec_wrap[15:0];
          if (st_i.remain_sec == 6'd0) begin
            if (st_i.remain_min == 7'd0) begin
              st.mode     = MODE_ALARM;
              start_pulse = 1'b1;
            end else begin
              st.remain_min = st_i.remain_min - 7'd1;
              st.remain_sec = SECONDS_TOP;
            end
          end else begin
            st.remain_sec = st_i.remain_sec - 6'd1;
          end
        end else begin
          st.sec_cnt = sec_sum[15:0];
        end
      end
      MODE_PAUSED: begin
        if (button_i == BTN_MIDDLE) begin
          st.mode    = MODE_RUNNING;
          st.sec_cnt = 16'd0;
        end else if (button_i == BTN_LEFT || button_i == BTN_RIGHT) begin
          st.mode = MODE_IDLE;
        end
      end
      MODE_ALARM: begin
        if (button_i != BTN_RELEASED) begin
          stop_pulse = 1'b1;
          st.mode    = MODE_IDLE;
        end
      end
      default: begin
        if (button_i == BTN_LEFT) begin
          st.mode = MODE_SET_MIN;
        end else if (button_i == BTN_RIGHT) begin
          st.mode = MODE_SET_SEC;
        end else if (button_i == BTN_MIDDLE) begin
          if (st_i.preset_min != 7'd0 || st_i.preset_sec != 6'd0) begin
            st.remain_min = st_i.preset_min;
            st.remain_sec = st_i.preset_sec;
            st.mode       = MODE_RUNNING;
            st.sec_cnt    = 16'd0;
          end
        end
      end
    endcase

    if (blink_hit) begin
      st.blink_phase = ~st_i.blink_phase;
      st.blink_cnt   = 16'd0;
    end else begin
      st.blink_cnt = blink_sum[15:0];
    end
  end

  always_comb begin
    if (st.mode == MODE_RUNNING || st.mode == MODE_PAUSED) begin
      dmin = st.remain_min;
      dsec = st.remain_sec;
    end else begin
      dmin = st.preset_min;
      dsec = st.preset_sec;
    end
    colon = 1'b1;
    blank = 1'b0;
    if ((st.mode == MODE_SET_MIN || st.mode == MODE_SET_SEC) && !st.blink_phase) begin
      colon = 1'b0;
    end else if (st.mode == MODE_PAUSED && !st.blink_phase) begin
      blank = 1'b1;
    end else if (st.mode == MODE_ALARM) begin
      blank = ~st.blink_phase;
      dmin  = 7'd0;
      dsec  = 6'd0;
    end
    if (blank) begin
      dmin  = 7'd0;
      dsec  = 6'd0;
      colon = 1'b0;
    end
  end

  assign st_o                = st;
  assign res_o.show_minutes  = dmin;
  assign res_o.show_seconds  = dsec;
  assign res_o.colon_lit     = colon;
  assign res_o.blank_display = blank;
  assign res_o.alarm_start   = start_pulse;
  assign res_o.alarm_stop    = stop_pulse;
  assign res_o.mode_now      = st.mode;

endmodule
